[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue unit
// Sizes of the ring store, request and status codes, and ring index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Store geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Request codes; the two unused codes fall to the default arm
    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_POP_FRONT  = 3'd1,
        MODE_PEEK_FRONT = 3'd2,
        MODE_PUSH_BACK  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_CLEAR      = 3'd5
    } t_deq_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_deq_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture the request word and launch the slot read
        logic commit;   // update the queue state and load the result register
    } t_deq_cmd;

    // Status from the datapath
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } t_deq_sts;

    // Advance a ring index by an offset below DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Step a ring index back by one slot
    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] res;
        if (base == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = base - ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

[hdl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer for the double-ended queue unit
// Takes one request word, lets the slot read settle, then commits the result
// into the output register once that register is free.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output deq_pkg::t_deq_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   commit;

    // Decode handshakes into datapath commands
    always_comb begin
        accept = i_valid && r_in_ready;
        commit = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    end

    // Next state and registered outputs
    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_in_ready  = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // Hold state and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready      = r_in_ready;
    assign o_valid      = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.commit = commit;

endmodule

[hdl/deq_dpath.sv]
// ----------------------------------------------------------------------------
// deq_dpath: ring store, front index and word count of the queue
// Reads the addressed slot on accept, then on commit applies the request,
// writes a pushed word and loads the result register.
// ----------------------------------------------------------------------------
module deq_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_deq_cmd              i_cmd,
    input  logic [2:0]                     i_mode,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_data_in,
    output logic [deq_pkg::DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]                     o_status,
    output logic [deq_pkg::CNT_W-1:0]      o_count_out,
    output deq_pkg::t_deq_sts              o_sts
);

    logic [deq_pkg::DATA_WIDTH-1:0] r_mem [deq_pkg::DEPTH];
    logic [deq_pkg::DATA_WIDTH-1:0] r_rd_data;
    logic [deq_pkg::ADDR_W-1:0]     rd_addr;

    logic [deq_pkg::ADDR_W-1:0]     r_front;
    logic [deq_pkg::ADDR_W-1:0]     n_front;
    logic [deq_pkg::CNT_W-1:0]      r_count;
    logic [deq_pkg::CNT_W-1:0]      n_count;

    deq_pkg::t_deq_mode             r_mode;
    logic [deq_pkg::DATA_WIDTH-1:0] r_word;

    logic                           wr_en;
    logic [deq_pkg::ADDR_W-1:0]     wr_addr;
    logic [deq_pkg::DATA_WIDTH-1:0] n_result;
    deq_pkg::t_deq_status           n_status;

    logic [deq_pkg::DATA_WIDTH-1:0] r_data_out;
    deq_pkg::t_deq_status           r_status;
    logic [deq_pkg::CNT_W-1:0]      r_count_out;

    logic                           is_empty;
    logic                           is_full;
    logic [deq_pkg::ADDR_W-1:0]     back_off;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign back_off = deq_pkg::ADDR_W'(r_count - deq_pkg::CNT_W'(1));

    // Pick the slot to read: the back word for pop back, else the front word
    always_comb begin
        if (deq_pkg::t_deq_mode'(i_mode) == deq_pkg::MODE_POP_BACK) begin
            rd_addr = deq_pkg::ring_add(r_front, back_off);
        end else begin
            rd_addr = r_front;
        end
    end

    // Apply the request to the indices and form the result
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_result = '0;
        n_status = deq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = deq_pkg::ring_dec(r_front);
        case (r_mode)
            deq_pkg::MODE_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = deq_pkg::ring_dec(r_front);
                    n_front = deq_pkg::ring_dec(r_front);
                    n_count = r_count + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::MODE_PUSH_BACK: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = deq_pkg::ring_add(r_front, deq_pkg::ADDR_W'(r_count));
                    n_count = r_count + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_result = r_rd_data;
                    n_front  = deq_pkg::ring_add(r_front, deq_pkg::ADDR_W'(1));
                    n_count  = r_count - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::MODE_PEEK_FRONT: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_result = r_rd_data;
                end
            end
            deq_pkg::MODE_POP_BACK: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_result = r_rd_data;
                    n_count  = r_count - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::MODE_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    // Ring store: read on accept, write a pushed word on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= r_word;
        end
    end

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= deq_pkg::t_deq_mode'(i_mode);
            r_word <= i_data_in;
        end
    end

    // Hold the queue indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_data_out  <= n_result;
            r_status    <= n_status;
            r_count_out <= n_count;
        end
    end

    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count_out = r_count_out;
    assign o_sts.count = r_count;
    assign o_sts.empty = is_empty;
    assign o_sts.full  = is_full;

endmodule

[hdl/double_ended_queue_unit.sv]
// Sequence: a request word is taken in S_IDLE, its slot read is registered, and the
// result register is loaded on the commit in S_EXEC; a stalled result delays the commit.
// A new word is taken only once the last one has committed.
// Reset: synchronous, active low; empties the queue, front index to slot zero.
// Store contents are not cleared; only live slots are ever returned in a result.
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of data words
// Push and pop at either end, peek at the front, clear; one result per word.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [2:0]                     i_mode,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_data_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [deq_pkg::DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]                     o_status,
    output logic [deq_pkg::CNT_W-1:0]      o_count_out
);

    deq_pkg::t_deq_cmd cmd;
    deq_pkg::t_deq_sts sts;

    // Sequencer
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Ring store and indices
    deq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out),
        .o_sts       (sts)
    );

    // A pending result always reports the count that the queue holds
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count_out == sts.count))
        else $error("result count differs from queue count");

    // A rejected push is only reported while the queue is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == deq_pkg::ST_FULL)) |-> sts.full)
        else $error("full status while queue not full");

    // An empty status is only reported while the queue is empty
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == deq_pkg::ST_EMPTY)) |-> sts.empty)
        else $error("empty status while queue holds words");

    // A commit always leaves a result pending in the next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_valid)
        else $error("commit did not load the result register");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: regression for the double-ended queue unit
// Drives push, pop, peek, clear and spare-code words through the request channel with
// random gaps, mirrors the ring store in a shadow deque and checks every
// response word field by field against the shadow's answer, in order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that have no meaning to the unit and must act as no-ops
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int MAX_GAP      = 18;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [deq_pkg::DATA_WIDTH-1:0] data;
        logic [1:0]                     status;
        logic [deq_pkg::CNT_W-1:0]      count;
    } t_deq_response;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [2:0]                     i_mode;
    logic [deq_pkg::DATA_WIDTH-1:0] i_data_in;
    logic                           o_valid;
    logic                           i_ready;
    logic [deq_pkg::DATA_WIDTH-1:0] o_data_out;
    logic [1:0]                     o_status;
    logic [deq_pkg::CNT_W-1:0]      o_count_out;

    // Shadow copy of the deque
    logic [deq_pkg::DATA_WIDTH-1:0] shadow_slots [deq_pkg::DEPTH];
    logic [deq_pkg::ADDR_W-1:0]     shadow_front;
    logic [deq_pkg::CNT_W-1:0]      shadow_count;

    t_deq_response responses_due[$];
    int            mismatch_count = 0;
    bit            no_idle = 1'b0;

    double_ended_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow deque and return the response it owes
    function automatic t_deq_response apply_request(logic [2:0] mode,
                                                    logic [deq_pkg::DATA_WIDTH-1:0] word);
        t_deq_response resp;
        int unsigned   slot;
        resp        = '0;
        resp.status = deq_pkg::ST_OK;
        case (mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
                if (shadow_count == deq_pkg::DEPTH) begin
                    resp.status = deq_pkg::ST_FULL;
                end else begin
                    if (mode == deq_pkg::MODE_PUSH_FRONT) begin
                        shadow_front = deq_pkg::ADDR_W'((shadow_front + deq_pkg::DEPTH - 1)
                                                        % deq_pkg::DEPTH);
                        slot         = shadow_front;
                    end else begin
                        slot = (shadow_front + shadow_count) % deq_pkg::DEPTH;
                    end
                    shadow_slots[slot] = word;
                    shadow_count++;
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_PEEK_FRONT: begin
                if (shadow_count == 0) begin
                    resp.status = deq_pkg::ST_EMPTY;
                end else begin
                    resp.data = shadow_slots[shadow_front];
                    if (mode == deq_pkg::MODE_POP_FRONT) begin
                        shadow_front = deq_pkg::ADDR_W'((shadow_front + 1) % deq_pkg::DEPTH);
                        shadow_count--;
                    end
                end
            end
            deq_pkg::MODE_POP_BACK: begin
                if (shadow_count == 0) begin
                    resp.status = deq_pkg::ST_EMPTY;
                end else begin
                    slot      = (shadow_front + shadow_count - 1) % deq_pkg::DEPTH;
                    resp.data = shadow_slots[slot];
                    shadow_count--;
                end
            end
            deq_pkg::MODE_CLEAR: begin
                shadow_front = '0;
                shadow_count = '0;
            end
            default: ;
        endcase
        resp.count = shadow_count;
        return resp;
    endfunction

    task automatic report_mismatch(string what, logic [deq_pkg::DATA_WIDTH-1:0] want,
                                   logic [deq_pkg::DATA_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Predict on each accepted request word, check each accepted response word
    always @(posedge i_clk) begin : response_check
        t_deq_response due;
        if (!i_rst_n) begin
            shadow_front = '0;
            shadow_count = '0;
            responses_due.delete();
        end else begin
            if (i_valid && o_ready) begin
                responses_due.push_back(apply_request(i_mode, i_data_in));
            end
            if (o_valid && i_ready) begin
                if (responses_due.size() == 0) begin
                    report_mismatch("unexpected response data_out", '0, o_data_out);
                end else begin
                    due = responses_due.pop_front();
                    if (o_data_out !== due.data) begin
                        report_mismatch("data_out", due.data, o_data_out);
                    end
                    if (o_status !== due.status) begin
                        report_mismatch("status", deq_pkg::DATA_WIDTH'(due.status),
                                        deq_pkg::DATA_WIDTH'(o_status));
                    end
                    if (o_count_out !== due.count) begin
                        report_mismatch("count_out", deq_pkg::DATA_WIDTH'(due.count),
                                        deq_pkg::DATA_WIDTH'(o_count_out));
                    end
                end
            end
        end
    end

    // Response side: hold ready low for a random stall before each word, none while no_idle is set
    initial begin : response_sink
        int stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Send one request word after a random gap; return at the accepting edge
    task automatic send_request(logic [2:0] mode, logic [deq_pkg::DATA_WIDTH-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_data_in <= word;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold the request side until every owed response has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (responses_due.size() != 0);
    endtask

    function automatic logic [deq_pkg::DATA_WIDTH-1:0] random_word();
        logic [deq_pkg::DATA_WIDTH-1:0] word;
        case ($urandom_range(0, 7))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
        endcase
        return word;
    endfunction

    // Mostly pushes and pops, split between pushes and pops by push_pct
    function automatic logic [2:0] random_mode(int push_pct);
        int         pick;
        logic [2:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            mode = deq_pkg::MODE_CLEAR;
        end else if (pick < 3) begin
            mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        end else if (pick < 10) begin
            mode = deq_pkg::MODE_PEEK_FRONT;
        end else if ($urandom_range(0, 99) < push_pct) begin
            mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
        end else begin
            mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_BACK;
        end
        return mode;
    endfunction

    // Every pop, peek and clear request on an empty queue, spare codes included
    task automatic test_empty_queue();
        send_request(deq_pkg::MODE_POP_FRONT, '1);
        send_request(deq_pkg::MODE_POP_BACK, '1);
        send_request(deq_pkg::MODE_PEEK_FRONT, '0);
        send_request(deq_pkg::MODE_CLEAR, '1);
        send_request(MODE_SPARE_6, '1);
        send_request(MODE_SPARE_7, '0);
    endtask

    // Fill from both ends past the front wrap, reject pushes when full, peek, pop both ends, clear
    task automatic test_full_queue();
        logic [deq_pkg::DATA_WIDTH-1:0] word;
        for (int i = 0; i < deq_pkg::DEPTH; i++) begin
            case (i)
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'hAAAA_AAAA;
                3:       word = 32'h5555_5555;
                default: word = $urandom;
            endcase
            send_request(i[0] ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK, word);
        end
        send_request(deq_pkg::MODE_PUSH_FRONT, '1);
        send_request(deq_pkg::MODE_PUSH_BACK, '1);
        send_request(deq_pkg::MODE_PEEK_FRONT, '0);
        send_request(deq_pkg::MODE_POP_FRONT, '0);
        send_request(deq_pkg::MODE_POP_BACK, '0);
        send_request(deq_pkg::MODE_CLEAR, '0);
    endtask

    // Segments that lean to filling, draining or neither, some without gaps
    task automatic test_random_traffic(int n_items);
        int sent;
        int seg_len;
        int push_pct;
        sent = 0;
        while (sent < n_items) begin
            seg_len = $urandom_range(10, 50);
            case ($urandom_range(0, 3))
                0:       push_pct = 85;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
                send_request(random_mode(push_pct), random_word());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // Pause the sender with words in flight, then resume on a settled queue
    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++) begin
            send_request(deq_pkg::MODE_PUSH_BACK, random_word());
        end
        wait_for_drain();
        send_request(deq_pkg::MODE_POP_FRONT, '0);
        send_request(deq_pkg::MODE_POP_BACK, '0);
        send_request(deq_pkg::MODE_PEEK_FRONT, '0);
        send_request(deq_pkg::MODE_POP_FRONT, '0);
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_mode    <= deq_pkg::MODE_PEEK_FRONT;
        i_data_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_full_queue();
        test_random_traffic(200);
        test_drain_pause();
        test_random_traffic(200);

        // Let the last responses land, then allow for anything stray
        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && responses_due.size() == 0) begin
            $display("double_ended_queue_unit regression: pass");
        end else begin
            $display("double_ended_queue_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule
